// ----- src/rids_pkg.sv -----
`default_nettype none

package rids_pkg;

  // Table capacity and derived widths
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FILL_W = 5;
  localparam int KEY_W  = 32;
  localparam int CMD_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_OLDEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd3;

  // Per-cell controls driven by the sequencer
  typedef struct packed {
    logic live;       // cell holds an entry
    logic cmp_en;     // capture key compare
    logic take_new;   // load the request key as newest entry
    logic take_next;  // load the neighbor's entry (close a gap)
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/rids_cell.sv -----
`default_nettype none

module rids_cell (
  input  wire                      clk,
  input  wire rids_pkg::cell_ctrl_t ctrl,
  input  wire [rids_pkg::KEY_W-1:0] key_addr,
  input  wire [rids_pkg::KEY_W-1:0] key_num,
  input  wire [rids_pkg::KEY_W-1:0] next_addr,
  input  wire [rids_pkg::KEY_W-1:0] next_num,
  output logic [rids_pkg::KEY_W-1:0] addr,
  output logic [rids_pkg::KEY_W-1:0] num,
  output logic                      hit
);

  logic [rids_pkg::KEY_W-1:0] addr_r;
  logic [rids_pkg::KEY_W-1:0] num_r;
  logic                       hit_r;

  // Load a new entry or take over the neighbor's entry
  always_ff @(posedge clk) begin
    if (ctrl.take_new) begin
      addr_r <= key_addr;
      num_r  <= key_num;
    end else if (ctrl.take_next) begin
      addr_r <= next_addr;
      num_r  <= next_num;
    end
  end

  // Capture the key compare for this cell
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      hit_r <= ctrl.live && (addr_r == key_addr) && (num_r == key_num);
    end
  end

  assign addr = addr_r;
  assign num  = num_r;
  assign hit  = hit_r;

endmodule

`default_nettype wire

// ----- src/request_id_seen_table.sv -----
// Channel   Ports                                              Direction
// request   start, busy, in_cmd, in_orig_addr, in_request_num  in (start & !busy)
// result    out_valid, out_ok, out_found_addr, out_found_num,  out (one-cycle strobe)
//           out_fill_level
//
// Each request passes through capture, parallel compare in every cell, then
// select the newest hit and shift the cell row. busy is high for the compare
// and execute cycles; the result strobes in the cycle after execute, the same
// cycle a new request may be accepted. rst_n (synchronous) empties the table.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module request_id_seen_table (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire [rids_pkg::CMD_W-1:0]    in_cmd,
  input  wire [rids_pkg::KEY_W-1:0]    in_orig_addr,
  input  wire [rids_pkg::KEY_W-1:0]    in_request_num,
  output logic                         out_valid,
  output logic                         out_ok,
  output logic [rids_pkg::KEY_W-1:0]   out_found_addr,
  output logic [rids_pkg::KEY_W-1:0]   out_found_num,
  output logic [rids_pkg::FILL_W-1:0]  out_fill_level
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [rids_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [rids_pkg::CMD_W-1:0]    cmd_r;
  logic [rids_pkg::KEY_W-1:0]    key_addr_r;
  logic [rids_pkg::KEY_W-1:0]    key_num_r;
  logic                          out_valid_r;
  logic                          out_ok_r;
  logic [rids_pkg::KEY_W-1:0]    out_addr_r;
  logic [rids_pkg::KEY_W-1:0]    out_num_r;
  logic [rids_pkg::FILL_W-1:0]   out_fill_r;

  rids_pkg::cell_ctrl_t          ctrl  [rids_pkg::DEPTH];
  logic [rids_pkg::KEY_W-1:0]    c_addr [rids_pkg::DEPTH];
  logic [rids_pkg::KEY_W-1:0]    c_num  [rids_pkg::DEPTH];
  logic [rids_pkg::DEPTH-1:0]    c_hit;

  logic                          accept;
  logic                          is_exec;
  logic                          any_hit;
  logic [rids_pkg::IDX_W-1:0]    hit_pos;
  logic [rids_pkg::IDX_W-1:0]    pos;
  logic                          exec_ok;
  logic                          do_insert;
  logic                          do_remove;

  assign accept  = start && (state_r == ST_IDLE);
  assign is_exec = (state_r == ST_EXEC);
  assign busy    = (state_r != ST_IDLE);

  // Advance the sequencer
  always_comb begin
    case (state_r)
      ST_IDLE:  state_nxt = accept ? ST_MATCH : ST_IDLE;
      ST_MATCH: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Pick the newest matching cell
  always_comb begin
    any_hit = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < rids_pkg::DEPTH; i++) begin
      if (c_hit[i]) begin
        any_hit = 1'b1;
        hit_pos = rids_pkg::IDX_W'(i);
      end
    end
  end

  // Decode the command
  always_comb begin
    exec_ok   = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    pos       = hit_pos;
    count_nxt = count_r;
    case (cmd_r)
      rids_pkg::CMD_INSERT: begin
        exec_ok   = (count_r < rids_pkg::CNT_W'(rids_pkg::DEPTH));
        do_insert = exec_ok;
      end
      rids_pkg::CMD_POP_OLDEST: begin
        exec_ok   = (count_r != '0);
        do_remove = exec_ok;
        pos       = '0;
      end
      rids_pkg::CMD_REMOVE: begin
        exec_ok   = any_hit;
        do_remove = any_hit;
      end
      rids_pkg::CMD_LOOKUP: begin
        exec_ok = any_hit;
      end
      default: begin
        exec_ok = 1'b0;
      end
    endcase
    if (is_exec && do_insert) begin
      count_nxt = count_r + 1'b1;
    end else if (is_exec && do_remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Drive the cell row
  for (genvar g = 0; g < rids_pkg::DEPTH; g++) begin : g_cell
    logic [rids_pkg::KEY_W-1:0] nxt_addr;
    logic [rids_pkg::KEY_W-1:0] nxt_num;

    always_comb begin
      ctrl[g].live      = (rids_pkg::CNT_W'(g) < count_r);
      ctrl[g].cmp_en    = (state_r == ST_MATCH);
      ctrl[g].take_new  = is_exec && do_insert && (rids_pkg::CNT_W'(g) == count_r);
      ctrl[g].take_next = is_exec && do_remove && (rids_pkg::IDX_W'(g) >= pos);
    end

    if (g == rids_pkg::DEPTH - 1) begin : g_tail
      assign nxt_addr = key_addr_r;
      assign nxt_num  = key_num_r;
    end else begin : g_link
      assign nxt_addr = c_addr[g+1];
      assign nxt_num  = c_num[g+1];
    end

    rids_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .key_addr  (key_addr_r),
      .key_num   (key_num_r),
      .next_addr (nxt_addr),
      .next_num  (nxt_num),
      .addr      (c_addr[g]),
      .num       (c_num[g]),
      .hit       (c_hit[g])
    );
  end

  // Hold the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_cmd;
      key_addr_r <= in_orig_addr;
      key_num_r  <= in_request_num;
    end
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= is_exec;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (is_exec) begin
      out_ok_r   <= exec_ok;
      out_fill_r <= rids_pkg::FILL_W'(count_nxt);
      if (exec_ok && (cmd_r != rids_pkg::CMD_INSERT)) begin
        out_addr_r <= c_addr[pos];
        out_num_r  <= c_num[pos];
      end else begin
        out_addr_r <= '0;
        out_num_r  <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_found_addr = out_addr_r;
  assign out_found_num  = out_num_r;
  assign out_fill_level = out_fill_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rids_pkg::CNT_W'(rids_pkg::DEPTH))
    else $error("entry count above capacity");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(is_exec))
    else $error("result strobe without execute cycle");

  a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(is_exec)) |-> $stable(count_r))
    else $error("entry count changed outside execute");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_addr_r == '0 && out_num_r == '0))
    else $error("failed request returned nonzero entry");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule

`default_nettype wire

// ----- test/tb_request_id_seen_table.sv -----
`timescale 1ns / 100ps

module tb_request_id_seen_table;

  localparam int RANDOM_REQS = 1950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 60;

  typedef struct {
    logic [rids_pkg::CMD_W-1:0] cmd;
    logic [rids_pkg::KEY_W-1:0] addr;
    logic [rids_pkg::KEY_W-1:0] num;
    int                         gap;
  } request_t;

  typedef struct {
    logic                        ok;
    logic [rids_pkg::KEY_W-1:0]  found_addr;
    logic [rids_pkg::KEY_W-1:0]  found_num;
    logic [rids_pkg::FILL_W-1:0] fill_level;
  } reply_t;

  typedef struct {
    logic [rids_pkg::KEY_W-1:0] addr;
    logic [rids_pkg::KEY_W-1:0] num;
  } key_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic [rids_pkg::CMD_W-1:0]  in_cmd = rids_pkg::CMD_LOOKUP;
  logic [rids_pkg::KEY_W-1:0]  in_orig_addr = '0;
  logic [rids_pkg::KEY_W-1:0]  in_request_num = '0;
  wire                         busy;
  wire                         out_valid;
  wire                         out_ok;
  wire [rids_pkg::KEY_W-1:0]   out_found_addr;
  wire [rids_pkg::KEY_W-1:0]   out_found_num;
  wire [rids_pkg::FILL_W-1:0]  out_fill_level;

  request_t          request_q[$];
  reply_t            reply_q[$];
  int                wait_left = 0;
  int                err_count = 0;
  int                cycle_count = 0;

  // Shadow copy of the table, oldest entry in slot 0
  logic [rids_pkg::KEY_W-1:0]  tbl_addr[rids_pkg::DEPTH];
  logic [rids_pkg::KEY_W-1:0]  tbl_num[rids_pkg::DEPTH];
  int                          tbl_count = 0;

  request_id_seen_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_orig_addr   (in_orig_addr),
    .in_request_num (in_request_num),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_found_addr (out_found_addr),
    .out_found_num  (out_found_num),
    .out_fill_level (out_fill_level)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Drop slot pos and shift newer entries toward the oldest
  task automatic drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < tbl_count; i++) begin
      tbl_addr[i] = tbl_addr[i + 1];
      tbl_num[i]  = tbl_num[i + 1];
    end
    tbl_count--;
  endtask

  // Apply one accepted request to the shadow table and queue its reply
  task automatic apply_request(input logic [rids_pkg::CMD_W-1:0] cmd,
                               input logic [rids_pkg::KEY_W-1:0] addr,
                               input logic [rids_pkg::KEY_W-1:0] num);
    reply_t r;
    int     pos;
    int     i;
    r.ok         = 1'b0;
    r.found_addr = '0;
    r.found_num  = '0;
    pos          = -1;
    case (cmd)
      rids_pkg::CMD_INSERT: begin
        if (tbl_count < rids_pkg::DEPTH) begin
          tbl_addr[tbl_count] = addr;
          tbl_num[tbl_count]  = num;
          tbl_count++;
          r.ok = 1'b1;
        end
      end
      rids_pkg::CMD_POP_OLDEST: begin
        if (tbl_count > 0) begin
          r.found_addr = tbl_addr[0];
          r.found_num  = tbl_num[0];
          drop_slot(0);
          r.ok = 1'b1;
        end
      end
      default: begin
        // Search from the newest entry down
        for (i = tbl_count - 1; i >= 0 && pos < 0; i--) begin
          if (tbl_addr[i] == addr && tbl_num[i] == num) pos = i;
        end
        if (pos >= 0) begin
          r.found_addr = tbl_addr[pos];
          r.found_num  = tbl_num[pos];
          r.ok         = 1'b1;
          if (cmd == rids_pkg::CMD_REMOVE) drop_slot(pos);
        end
      end
    endcase
    r.fill_level = tbl_count[rids_pkg::FILL_W-1:0];
    reply_q.push_back(r);
  endtask

  task automatic add_request(input logic [rids_pkg::CMD_W-1:0] cmd,
                             input logic [rids_pkg::KEY_W-1:0] addr,
                             input logic [rids_pkg::KEY_W-1:0] num, input int gap);
    request_t q;
    q.cmd  = cmd;
    q.addr = addr;
    q.num  = num;
    q.gap  = gap;
    request_q.push_back(q);
  endtask

  // Driver: hold each request until accepted, then wait its gap
  always @(posedge clk) begin
    int       waitv;
    request_t q;
    if (!rst_n) begin
      start     <= 1'b0;
      wait_left <= 0;
    end else if (!start || !busy) begin
      if (start) begin
        apply_request(in_cmd, in_orig_addr, in_request_num);
        waitv = (request_q.size() > 0) ? request_q[0].gap : 0;
      end else begin
        waitv = wait_left;
      end
      if (waitv == 0 && request_q.size() > 0) begin
        q = request_q.pop_front();
        in_cmd         <= q.cmd;
        in_orig_addr   <= q.addr;
        in_request_num <= q.num;
        start          <= 1'b1;
      end else begin
        start     <= 1'b0;
        wait_left <= (waitv > 0) ? waitv - 1 : 0;
      end
    end
  end

  // Monitor: compare each result strobe with the oldest queued reply
  always @(posedge clk) begin
    reply_t r;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        r = reply_q.pop_front();
        if (out_ok !== r.ok || out_found_addr !== r.found_addr ||
            out_found_num !== r.found_num || out_fill_level !== r.fill_level) begin
          report_mismatch($sformatf({"got ok=%0b addr=%h num=%h fill=%0d, ",
                                     "want ok=%0b addr=%h num=%h fill=%0d"},
            out_ok, out_found_addr, out_found_num, out_fill_level,
            r.ok, r.found_addr, r.found_num, r.fill_level));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("request_id_seen_table: mismatch");
      $finish;
    end
  end

  initial begin
    key_t                       pool[$];
    key_t                       k;
    logic [rids_pkg::CMD_W-1:0] cmd;
    logic [rids_pkg::KEY_W-1:0] addr;
    logic [rids_pkg::KEY_W-1:0] num;
    int                         ins_pct;
    int                         no_idle;
    int                         sel;
    int                         gap;
    int                         n;

    // Empty table: every lookup or removal fails
    add_request(rids_pkg::CMD_LOOKUP, '0, '0, $urandom_range(0, 17));
    add_request(rids_pkg::CMD_POP_OLDEST, '0, '0, $urandom_range(0, 17));
    add_request(rids_pkg::CMD_REMOVE, '1, '1, $urandom_range(0, 17));
    // Extreme keys and a duplicate entry
    add_request(rids_pkg::CMD_INSERT, '0, '0, $urandom_range(0, 17));
    add_request(rids_pkg::CMD_INSERT, '1, '1, $urandom_range(0, 17));
    add_request(rids_pkg::CMD_INSERT, '0, '0, $urandom_range(0, 17));
    // Fill to capacity, including keys that match in one half only
    for (n = 0; n < rids_pkg::DEPTH - 3; n++) begin
      addr = (n == 0) ? '1 : (n == 1) ? '0 : $urandom;
      num  = (n == 0) ? '0 : (n == 1) ? '1 : $urandom;
      add_request(rids_pkg::CMD_INSERT, addr, num, $urandom_range(0, 17));
    end
    // Insert into a full table
    add_request(rids_pkg::CMD_INSERT, 32'h1234_5678, 32'h9abc_def0,
                $urandom_range(0, 17));
    // Hit on duplicates, partial-key miss, remove newest duplicate, pop oldest
    add_request(rids_pkg::CMD_LOOKUP, '0, '0, $urandom_range(0, 17));
    add_request(rids_pkg::CMD_LOOKUP, '0, 32'h1, $urandom_range(0, 17));
    add_request(rids_pkg::CMD_REMOVE, '0, '0, $urandom_range(0, 17));
    add_request(rids_pkg::CMD_POP_OLDEST, '0, '0, $urandom_range(0, 17));
    add_request(rids_pkg::CMD_POP_OLDEST, '1, '1, $urandom_range(0, 17));

    // Random traffic in blocks with drifting insert rate and idle mode
    ins_pct = 50;
    no_idle = 0;
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) begin
        ins_pct = $urandom_range(10, 90);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      addr = $urandom;
      num  = $urandom;
      sel  = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < ins_pct) begin
        cmd = rids_pkg::CMD_INSERT;
        if (sel < 3 && pool.size() > 0) begin
          k    = pool[$urandom_range(0, pool.size() - 1)];
          addr = k.addr;
          num  = k.num;
        end else if (sel < 5) begin
          addr = $urandom_range(0, 3);
          num  = $urandom_range(0, 3);
        end
        k.addr = addr;
        k.num  = num;
        pool.push_back(k);
        if (pool.size() > 24) void'(pool.pop_front());
      end else begin
        case ($urandom_range(0, 2))
          0: cmd = rids_pkg::CMD_POP_OLDEST;
          1: cmd = rids_pkg::CMD_REMOVE;
          default: cmd = rids_pkg::CMD_LOOKUP;
        endcase
        if (sel < 8 && pool.size() > 0) begin
          k    = pool[$urandom_range(0, pool.size() - 1)];
          addr = k.addr;
          num  = k.num;
          // Near miss: flip one key bit
          if (sel == 7) begin
            if ($urandom_range(0, 1)) addr = addr ^ (32'h1 << $urandom_range(0, 31));
            else num = num ^ (32'h1 << $urandom_range(0, 31));
          end
        end else if (sel == 8) begin
          addr = $urandom_range(0, 3);
          num  = $urandom_range(0, 3);
        end
      end
      gap = no_idle ? 0 : $urandom_range(0, 17);
      add_request(cmd, addr, num, gap);
    end

    // Wait for every request to be accepted and answered
    while (request_q.size() != 0 || start) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (reply_q.size() != 0) report_mismatch("reply still outstanding at end");

    if (err_count == 0) begin
      $display("request_id_seen_table: match");
    end else begin
      $display("request_id_seen_table: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rids_pkg.sv
src/rids_cell.sv
src/request_id_seen_table.sv
test/tb_request_id_seen_table.sv
